// ===== src/edmt_pkg.sv =====
// ----------------------------------------------------------------------------
// edmt_pkg: shared types and constants for the egg drop minimum trials block
// Field widths of the request and response streams, parameter defaults and
// the control struct between the sequencer and the compare unit.
// ----------------------------------------------------------------------------
package edmt_pkg;

   localparam int DEF_MAX_EGGS   = 16;
   localparam int DEF_MAX_FLOORS = 256;

   localparam int EGG_W       = 5;
   localparam int FLOOR_W     = 9;
   localparam int DROP_W      = 9;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   // control of the shared compare unit
   typedef struct packed {
      logic clear;   // start a new minimum search
      logic load;    // fold one table pair into the running minimum
   } acc_ctrl_type;

endpackage

// ===== src/edmt_table.sv =====
// ----------------------------------------------------------------------------
// edmt_table: scratch table memory
// One write port and two read ports with registered read data. Rows are
// egg counts, columns are floor counts.
// ----------------------------------------------------------------------------
module edmt_table
   import edmt_pkg::*;
#(
   parameter int ADDR_W = 13
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DROP_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DROP_W-1:0] rd_data_a,
   output logic [DROP_W-1:0] rd_data_b
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DROP_W-1:0] mem_ff [DEPTH];
   logic [DROP_W-1:0] rd_a_ff;
   logic [DROP_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== src/edmt_minmax.sv =====
// ----------------------------------------------------------------------------
// edmt_minmax: shared compare unit
// Takes one pair of table entries a cycle while load is set, forms one plus
// the larger of the two and keeps the running minimum over all first drop floors.
// ----------------------------------------------------------------------------
module edmt_minmax
   import edmt_pkg::*;
(
   input  logic              clock,
   input  acc_ctrl_type      ctrl,
   input  logic [DROP_W-1:0] broke,
   input  logic [DROP_W-1:0] held,
   output logic [DROP_W-1:0] best
);

   logic [DROP_W-1:0] best_ff;
   logic [DROP_W-1:0] best_in;
   logic [DROP_W-1:0] worst;

   // entries stay below the floor count, so the increment cannot wrap
   assign worst = ((broke > held) ? broke : held) + DROP_W'(1);

   always_comb begin
      priority if (ctrl.clear) begin
         best_in = '1;
      end else if (ctrl.load && (worst < best_ff)) begin
         best_in = worst;
      end else begin
         best_in = best_ff;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

   assign best = best_ff;

endmodule

// ===== src/egg_drop_min_trials.sv =====
// ----------------------------------------------------------------------------
// egg_drop_min_trials: worst-case minimum drops for an egg and floor count
// Fills a scratch table bottom-up, one row per egg count, and searches every
// first drop floor through one shared compare unit.
//
//   channel  dir  fields (tdata low bit up)          transfer
//   req_     in   egg_count[4:0] floor_count[13:5]  req_tvalid & req_tready
//   rsp_     out  min_drops[8:0]                    rsp_tvalid & rsp_tready
//
// A query with F floors, F at least one, reads one table pair per cycle
// through the two-port table memory. Zero floors read no table pairs.
// req_tready is high only while the sequencer is idle.
// The result waits in an output register; a new query is accepted meanwhile,
// but the sequencer holds in its last state while an earlier result waits.
// Reset is synchronous; the table needs no clearing since every entry is
// written before it is read.
// ----------------------------------------------------------------------------
module egg_drop_min_trials
   import edmt_pkg::*;
#(
   parameter int MAX_EGGS   = DEF_MAX_EGGS,
   parameter int MAX_FLOORS = DEF_MAX_FLOORS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // egg_count, floor_count, zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // min_drops, zero pad
);

   localparam int EGG_MAX_IN   = (1 << EGG_W) - 1;
   localparam int FLOOR_MAX_IN = (1 << FLOOR_W) - 1;
   localparam int EGG_LIM   = (MAX_EGGS < EGG_MAX_IN) ? MAX_EGGS : EGG_MAX_IN;
   localparam int FLOOR_LIM = (MAX_FLOORS < FLOOR_MAX_IN) ? MAX_FLOORS : FLOOR_MAX_IN;
   localparam int EW = (EGG_LIM > 1) ? $clog2(EGG_LIM) : 1;
   localparam int FW = $clog2(FLOOR_LIM + 1);
   localparam int AW = EW + FW;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ROW    = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_WRITE  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [EW-1:0]     row_ff, row_in;
   logic [EW-1:0]     last_row_ff, last_row_in;
   logic [FW-1:0]     flr_ff, flr_in;
   logic [FW-1:0]     last_flr_ff, last_flr_in;
   logic [FW-1:0]     idx_ff, idx_in;
   logic [DROP_W-1:0] result_ff, result_in;
   logic              pipe_ff, pipe_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DROP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [EGG_W-1:0]   req_eggs;
   logic [FLOOR_W-1:0] req_floors;
   logic [EGG_W-1:0]   eggs_eff;
   logic [FLOOR_W-1:0] floors_eff;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DROP_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr_a;
   logic [AW-1:0]     rd_addr_b;
   logic [DROP_W-1:0] rd_data_a;
   logic [DROP_W-1:0] rd_data_b;
   logic [DROP_W-1:0] best;
   acc_ctrl_type      acc_ctrl;

   logic req_xfer;
   logic rsp_xfer;
   logic trivial;

   assign req_eggs   = req_tdata[EGG_W-1:0];
   assign req_floors = req_tdata[EGG_W+FLOOR_W-1:EGG_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_valid_ff && rsp_tready;

   always_comb begin
      priority if (req_eggs == '0) begin
         eggs_eff = EGG_W'(1);
      end else if (req_eggs > EGG_W'(EGG_LIM)) begin
         eggs_eff = EGG_W'(EGG_LIM);
      end else begin
         eggs_eff = req_eggs;
      end
      floors_eff = (req_floors > FLOOR_W'(FLOOR_LIM)) ? FLOOR_W'(FLOOR_LIM) : req_floors;
   end

   // one egg or at most one floor: the entry is the floor count
   assign trivial = (row_ff == '0) || (flr_ff <= FW'(1));

   assign rd_addr_a = {EW'(row_ff - 1'b1), FW'(idx_ff - 1'b1)};
   assign rd_addr_b = {row_ff, FW'(flr_ff - idx_ff)};
   assign wr_addr   = {row_ff, flr_ff};
   assign wr_data   = (state_ff == ST_WRITE) ? best : DROP_W'(flr_ff);
   assign wr_en     = ((state_ff == ST_ROW) && trivial) || (state_ff == ST_WRITE);

   assign acc_ctrl.clear = (state_ff == ST_ROW) && !trivial;
   assign acc_ctrl.load  = pipe_ff;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      last_row_in  = last_row_ff;
      flr_in       = flr_ff;
      last_flr_in  = last_flr_ff;
      idx_in       = idx_ff;
      result_in    = result_ff;
      pipe_in      = (state_ff == ST_READ);
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      rsp_data_in  = rsp_data_ff;

      if (wr_en) begin
         result_in = wr_data;
         // step to the next entry, row by row
         if (flr_ff == last_flr_ff) begin
            if (row_ff == last_row_ff) begin
               state_in = ST_FINISH;
            end else begin
               row_in   = EW'(row_ff + 1'b1);
               flr_in   = '0;
               state_in = ST_ROW;
            end
         end else begin
            flr_in   = FW'(flr_ff + 1'b1);
            state_in = ST_ROW;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               last_row_in = EW'(eggs_eff - 1'b1);
               last_flr_in = FW'(floors_eff);
               row_in      = '0;
               flr_in      = '0;
               state_in    = ST_ROW;
            end
         end
         ST_ROW: begin
            if (!trivial) begin
               idx_in   = FW'(1);
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (idx_ff == flr_ff) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = FW'(idx_ff + 1'b1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pipe_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pipe_ff      <= pipe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      last_row_ff <= last_row_in;
      flr_ff      <= flr_in;
      last_flr_ff <= last_flr_in;
      idx_ff      <= idx_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   edmt_table #(
      .ADDR_W (AW)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   edmt_minmax u_minmax (
      .clock (clock),
      .ctrl  (acc_ctrl),
      .broke (rd_data_a),
      .held  (rd_data_b),
      .best  (best)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-DROP_W){1'b0}}, rsp_data_ff};

endmodule

// ===== src/edmt_checker.sv =====
// ----------------------------------------------------------------------------
// edmt_checker: port-level checks for egg_drop_min_trials
// Watches the stream handshakes and the busy behavior of the sequencer.
// ----------------------------------------------------------------------------
module edmt_checker
   import edmt_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // after a request transfer the block is busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // reset leaves the block idle with no result pending
   a_reset: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

   // padding bits above the answer stay zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_TDATA_W-1:DROP_W] == '0))
      else $error("nonzero padding in result");

endmodule

bind egg_drop_min_trials edmt_checker u_checker (.*);
